FILE: hw/rtl/apm_pkg.sv
// Shared constants, types and helpers of the approximate pattern match counter.
`timescale 1ns / 1ps
package apm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int WORD_COUNT  = 4;
   localparam int WORD_W      = 64;
   localparam int PAT_BYTES   = WORD_COUNT * 8;
   localparam int DIST_W      = 6;
   localparam int ROW_W       = $clog2(PATTERN_MAX + 1);
   localparam int LIMIT_W     = 5;
   localparam int LEN_W       = 6;
   localparam int COUNT_W     = 32;
   localparam int CSR_IDX_W   = 3;

   // column entry after reset, taken with the reset limit of zero
   localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_0 = 3'd0,
      CSR_PATTERN_1 = 3'd1,
      CSR_PATTERN_2 = 3'd2,
      CSR_PATTERN_3 = 3'd3,
      CSR_LENGTH    = 3'd4,
      CSR_LIMIT     = 3'd5
   } csr_index_type;

   // what one cell hands to its right neighbor
   typedef struct packed {
      logic              valid;
      logic [7:0]        text_byte;
      logic              first;
      logic [DIST_W-1:0] end_distance;
      logic [DIST_W-1:0] dist_new;
      logic [DIST_W-1:0] dist_old;
   } cell_link_type;

   typedef struct packed {
      logic [DIST_W-1:0] cap;
      logic [ROW_W-1:0]  used_length;
   } cell_cfg_type;

   typedef struct packed {
      logic               valid;
      logic               is_match;
      logic [COUNT_W-1:0] match_count;
      logic [DIST_W-1:0]  end_distance;
   } rsp_type;

   // column value at a given row after a column reset
   function automatic logic [DIST_W-1:0] row_floor(input logic [ROW_W-1:0] row,
                                                   input logic [DIST_W-1:0] cap);
      if (int'(row) < int'(cap)) begin
         return DIST_W'(row);
      end
      return cap;
   endfunction

   // clamp the programmed length into 1..PATTERN_MAX
   function automatic logic [ROW_W-1:0] used_length(input logic [LEN_W-1:0] len);
      if (len == '0) begin
         return ROW_W'(1);
      end
      if (int'(len) > PATTERN_MAX) begin
         return ROW_W'(PATTERN_MAX);
      end
      return ROW_W'(len);
   endfunction

endpackage

FILE: hw/rtl/apm_if.sv
// Request and response channel interfaces of the approximate pattern match counter.
`timescale 1ns / 1ps
interface apm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_of_text;

   modport source (output valid, output text_byte, output first_of_text, input ready);
   modport sink (input valid, input text_byte, input first_of_text, output ready);
endinterface

interface apm_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_match;
   logic [31:0] match_count;
   logic [5:0]  end_distance;

   modport source (output valid, output is_match, output match_count, output end_distance,
                   input ready);
   modport sink (input valid, input is_match, input match_count, input end_distance,
                 output ready);
endinterface

FILE: hw/rtl/apm_cell.sv
// One row of the distance column: update by the Sellers recurrence and hand right.
`timescale 1ns / 1ps
module apm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [apm_pkg::ROW_W-1:0]   row,
   input  logic [7:0]                  pattern_byte,
   input  apm_pkg::cell_cfg_type       cfg,
   input  apm_pkg::cell_link_type      link_in,
   output apm_pkg::cell_link_type      link_out
);
   import apm_pkg::*;

   logic              valid_ff;
   logic [7:0]        byte_ff;
   logic              first_ff;
   logic [DIST_W-1:0] end_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] prev_ff;

   logic [DIST_W-1:0] left_old;
   logic [DIST_W-1:0] own_old;
   logic [DIST_W-1:0] dist_in;
   logic [DIST_W-1:0] end_in;

   always_comb begin
      // a first byte sees the freshly reset column
      left_old = link_in.first ? row_floor(ROW_W'(row - ROW_W'(1)), cfg.cap)
                               : link_in.dist_old;
      own_old  = link_in.first ? row_floor(row, cfg.cap) : dist_ff;

      dist_in = left_old + ((pattern_byte == link_in.text_byte) ? DIST_W'(0) : DIST_W'(1));
      if ((own_old + DIST_W'(1)) < dist_in) begin
         dist_in = own_old + DIST_W'(1);
      end
      if ((link_in.dist_new + DIST_W'(1)) < dist_in) begin
         dist_in = link_in.dist_new + DIST_W'(1);
      end
      if (cfg.cap < dist_in) begin
         dist_in = cfg.cap;
      end

      end_in = (row == cfg.used_length) ? dist_in : link_in.end_distance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dist_ff  <= DIST_RESET;
      end else if (advance) begin
         valid_ff <= link_in.valid;
         if (link_in.valid) begin
            dist_ff <= dist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && link_in.valid) begin
         byte_ff  <= link_in.text_byte;
         first_ff <= link_in.first;
         end_ff   <= end_in;
         prev_ff  <= own_old;
      end
   end

   assign link_out.valid        = valid_ff;
   assign link_out.text_byte    = byte_ff;
   assign link_out.first        = first_ff;
   assign link_out.end_distance = end_ff;
   assign link_out.dist_new     = dist_ff;
   assign link_out.dist_old     = prev_ff;

endmodule

FILE: hw/rtl/apm_tally.sv
// End of the cell chain: match decision, saturating count and result register.
`timescale 1ns / 1ps
module apm_tally (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [apm_pkg::LIMIT_W-1:0]   edit_limit,
   input  apm_pkg::cell_link_type        link_in,
   output apm_pkg::rsp_type              rsp
);
   import apm_pkg::*;

   logic               rsp_valid_ff;
   logic               is_match_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [DIST_W-1:0]  end_ff;

   logic [COUNT_W-1:0] base;
   logic               hit;
   logic [COUNT_W-1:0] count_in;

   always_comb begin
      base     = link_in.first ? '0 : count_ff;
      hit      = link_in.end_distance <= DIST_W'(edit_limit);
      count_in = (hit && (base != '1)) ? base + COUNT_W'(1) : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (advance) begin
         rsp_valid_ff <= link_in.valid;
         if (link_in.valid) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && link_in.valid) begin
         is_match_ff <= hit;
         end_ff      <= link_in.end_distance;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.is_match     = is_match_ff;
   assign rsp.match_count  = count_ff;
   assign rsp.end_distance = end_ff;

endmodule

FILE: hw/rtl/approximate_pattern_match_counter_unit.sv
// Top level of the approximate pattern match counter: registers, cell chain, tally.
`timescale 1ns / 1ps
// Each text byte walks a chain of PATTERN_MAX (32) cells, one pattern row per cell, and
// then a tally stage, whose result register presents its result on the response channel.
// A new byte is taken every cycle; the whole chain holds while a result waits on a low
// rsp ready, which is what sets the rate under backpressure. Each cell keeps its row of
// the distance column, so bytes of one text follow each other back to back. The running
// match count lives in the tally stage. Write the pattern, length and limit registers only
// with the chain drained; a byte flagged first_of_text restarts the column and the count.
module approximate_pattern_match_counter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [apm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [apm_pkg::WORD_W-1:0]      csr_write_data,
   apm_req_if.sink                         req_ch,
   apm_rsp_if.source                       rsp_ch
);
   import apm_pkg::*;

   logic [WORD_COUNT-1:0][WORD_W-1:0] pattern_ff;
   logic [LEN_W-1:0]                  length_ff;
   logic [LIMIT_W-1:0]                limit_ff;

   cell_cfg_type                      cfg;
   cell_link_type                     links [PATTERN_MAX+1];
   rsp_type                           rsp;
   logic                              advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LEN_W'(1);
         limit_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_0: pattern_ff[0] <= csr_write_data;
            CSR_PATTERN_1: pattern_ff[1] <= csr_write_data;
            CSR_PATTERN_2: pattern_ff[2] <= csr_write_data;
            CSR_PATTERN_3: pattern_ff[3] <= csr_write_data;
            CSR_LENGTH:    length_ff     <= csr_write_data[LEN_W-1:0];
            CSR_LIMIT:     limit_ff      <= csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.cap         = DIST_W'(limit_ff) + DIST_W'(1);
   assign cfg.used_length = used_length(length_ff);

   // hold the whole chain while the result register is full and not taken
   assign advance      = !rsp.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // row 0 of the column is always zero
   assign links[0].valid        = req_ch.valid;
   assign links[0].text_byte    = req_ch.text_byte;
   assign links[0].first        = req_ch.first_of_text;
   assign links[0].end_distance = '0;
   assign links[0].dist_new     = '0;
   assign links[0].dist_old     = '0;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      logic [7:0] pat_byte;
      if (g < PAT_BYTES) begin : g_byte
         assign pat_byte = pattern_ff[g / 8][(g % 8) * 8 +: 8];
      end else begin : g_zero
         assign pat_byte = 8'd0;
      end

      apm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .row          (ROW_W'(g + 1)),
         .pattern_byte (pat_byte),
         .cfg          (cfg),
         .link_in      (links[g]),
         .link_out     (links[g + 1])
      );
   end

   apm_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .edit_limit (limit_ff),
      .link_in    (links[PATTERN_MAX]),
      .rsp        (rsp)
   );

   assign rsp_ch.valid        = rsp.valid;
   assign rsp_ch.is_match     = rsp.is_match;
   assign rsp_ch.match_count  = rsp.match_count;
   assign rsp_ch.end_distance = rsp.end_distance;

endmodule

FILE: hw/rtl/apm_checker.sv
// Port-level checker of the approximate pattern match counter, bound to the top level.
`timescale 1ns / 1ps
module apm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_write_enable,
   input logic [apm_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [apm_pkg::WORD_W-1:0]      csr_write_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            is_match,
   input logic [31:0]                     match_count,
   input logic [5:0]                      end_distance
);
   import apm_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;

   // track the programmed edit limit
   always_comb begin
      limit_in = limit_ff;
      if (csr_write_enable && (csr_index == CSR_LIMIT)) begin
         limit_in = csr_write_data[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_count)
                                  && $stable(end_distance))
      else $error("result transaction changed while stalled");

   a_match_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> is_match == (end_distance <= DIST_W'(limit_ff)))
      else $error("match flag disagrees with end distance and limit");

   a_dist_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> end_distance <= (DIST_W'(limit_ff) + DIST_W'(1)))
      else $error("end distance above limit plus one");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_match |-> match_count != '0)
      else $error("match reported with zero count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind approximate_pattern_match_counter_unit apm_checker u_apm_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .is_match         (rsp_ch.is_match),
   .match_count      (rsp_ch.match_count),
   .end_distance     (rsp_ch.end_distance)
);

FILE: test/apm_match_checker.sv
// Scoreboard for the approximate pattern match counter: column predictor and result compare.
`timescale 1ns / 1ps
module apm_match_checker
   import apm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data,
   apm_req_if                   req_mon,
   apm_rsp_if                   rsp_mon,
   output int                   mismatch_count,
   output int                   results_pending
);

   typedef struct packed {
      logic               is_match;
      logic [COUNT_W-1:0] match_count;
      logic [DIST_W-1:0]  end_distance;
   } scan_result_type;

   logic [WORD_W-1:0]  pat_word [WORD_COUNT];
   logic [LEN_W-1:0]   pat_len;
   logic [LIMIT_W-1:0] k_limit;
   int                 column [PATTERN_MAX+1];
   logic [COUNT_W-1:0] hits;
   scan_result_type    expected_scans [$];

   function automatic void restart_column();
      int cap;
      cap = int'(k_limit) + 1;
      for (int i = 0; i <= PATTERN_MAX; i++) begin
         column[i] = (i < cap) ? i : cap;
      end
      hits = '0;
   endfunction

   // advance the distance column by one text byte and form the result
   function automatic scan_result_type scan_byte(input logic [7:0] text, input logic first);
      int              cap;
      int              prev_old;
      int              prev_new;
      int              old;
      int              v;
      int              m;
      logic [7:0]      pbyte;
      scan_result_type r;
      cap = int'(k_limit) + 1;
      if (first) begin
         restart_column();
      end
      prev_old = column[0];
      prev_new = 0;
      column[0] = 0;
      for (int i = 1; i <= PATTERN_MAX; i++) begin
         old = column[i];
         pbyte = pat_word[(i-1)/8][((i-1)%8)*8 +: 8];
         v = prev_old + ((pbyte == text) ? 0 : 1);
         if (old + 1 < v) begin
            v = old + 1;
         end
         if (prev_new + 1 < v) begin
            v = prev_new + 1;
         end
         if (cap < v) begin
            v = cap;
         end
         column[i] = v;
         prev_old = old;
         prev_new = v;
      end
      m = int'(pat_len);
      if (m < 1) begin
         m = 1;
      end
      if (m > PATTERN_MAX) begin
         m = PATTERN_MAX;
      end
      r.end_distance = DIST_W'(column[m]);
      r.is_match = (column[m] <= int'(k_limit));
      // hold the count once it is full
      if (r.is_match && hits != '1) begin
         hits = hits + 1'b1;
      end
      r.match_count = hits;
      return r;
   endfunction

   always @(posedge clock) begin
      scan_result_type want;
      if (reset) begin
         for (int w = 0; w < WORD_COUNT; w++) begin
            pat_word[w] = '0;
         end
         pat_len = LEN_W'(1);
         k_limit = '0;
         restart_column();
         expected_scans.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_scans.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected result: is_match %0b count %0d distance %0d",
                           $realtime, rsp_mon.is_match, rsp_mon.match_count,
                           rsp_mon.end_distance);
               end
            end else begin
               want = expected_scans.pop_front();
               if (rsp_mon.is_match !== want.is_match ||
                   rsp_mon.match_count !== want.match_count ||
                   rsp_mon.end_distance !== want.end_distance) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch (expected/actual): is_match %0b/%0b count %0d/%0d distance %0d/%0d",
                              $realtime, want.is_match, rsp_mon.is_match,
                              want.match_count, rsp_mon.match_count,
                              want.end_distance, rsp_mon.end_distance);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_scans.insert(expected_scans.size(),
                                  scan_byte(req_mon.text_byte, req_mon.first_of_text));
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PATTERN_0, CSR_PATTERN_1, CSR_PATTERN_2, CSR_PATTERN_3: begin
                  pat_word[csr_index[1:0]] = csr_write_data;
               end
               CSR_LENGTH: begin
                  pat_len = csr_write_data[LEN_W-1:0];
               end
               CSR_LIMIT: begin
                  k_limit = csr_write_data[LIMIT_W-1:0];
               end
               default: begin
                  // drop writes to unused indexes
               end
            endcase
         end
      end
      results_pending = expected_scans.size();
   end

endmodule

FILE: test/tb.sv
// Testbench top for the approximate pattern match counter: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps
module tb;
   import apm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = PATTERN_MAX + 8;
   localparam int RANDOM_PHASES = 10;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_write_data;
   int                   mismatch_count;
   int                   results_pending;
   int                   stall_cycles;
   bit                   sender_gaps;
   bit                   receiver_stalls;

   // search setup as last programmed, used to shape the text
   logic [WORD_W-1:0]    search_word [WORD_COUNT];
   int                   search_len;
   int                   search_k;

   apm_req_if req_ch ();
   apm_rsp_if rsp_ch ();

   approximate_pattern_match_counter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   apm_match_checker match_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stall bursts; ready always comes back high after a burst before the next one
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (receiver_stalls && rsp_ch.ready && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic pause_sender(input int n);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_char(input logic [7:0] b, input logic first);
      if (sender_gaps && $urandom_range(0, 9) == 0) begin
         pause_sender($urandom_range(1, 19));
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= b;
      req_ch.first_of_text <= first;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_string(input string s, input bit first);
      for (int j = 0; j < s.len(); j++) begin
         send_char(s[j], first && j == 0);
      end
   endtask

   // hold the input side idle until every transaction has come back
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic reg_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic reg_write_done();
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_search();
      reg_write(CSR_PATTERN_0, search_word[0]);
      reg_write(CSR_PATTERN_1, search_word[1]);
      reg_write(CSR_PATTERN_2, search_word[2]);
      reg_write(CSR_PATTERN_3, search_word[3]);
      reg_write(CSR_LENGTH, WORD_W'(search_len));
      reg_write(CSR_LIMIT, WORD_W'(search_k));
   endtask

   task automatic pick_search();
      int alpha;
      int base;
      alpha = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(2, 4);
      base = (alpha == 256) ? 0 : $urandom_range(0, 255 - alpha);
      for (int p = 0; p < PAT_BYTES; p++) begin
         search_word[p/8][(p%8)*8 +: 8] = 8'(base + $urandom_range(0, alpha - 1));
      end
      case ($urandom_range(0, 9))
         0: search_len = PATTERN_MAX;
         1: search_len = $urandom_range(PATTERN_MAX + 1, 63);
         2: search_len = 0;
         default: search_len = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 7))
         0: search_k = 31;
         1: search_k = $urandom_range(4, 31);
         default: search_k = $urandom_range(0, 3);
      endcase
   endtask

   // mostly edited copies of the pattern, with runs of noise between them
   task automatic emit_text(input int n_items, input bit open_text);
      logic [7:0] seg [$];
      logic [7:0] pb;
      int         m;
      int         sent;
      int         pos;
      bit         first_pending;
      m = search_len;
      if (m < 1) begin
         m = 1;
      end
      if (m > PATTERN_MAX) begin
         m = PATTERN_MAX;
      end
      sent = 0;
      first_pending = open_text;
      while (sent < n_items) begin
         seg.delete();
         if ($urandom_range(0, 9) < 7) begin
            for (int p = 0; p < m; p++) begin
               pb = search_word[p/8][(p%8)*8 +: 8];
               case ($urandom_range(0, 19))
                  0: begin
                     // deletion
                  end
                  1: seg.insert(seg.size(), 8'($urandom));
                  2: begin
                     seg.insert(seg.size(), 8'($urandom));
                     seg.insert(seg.size(), pb);
                  end
                  default: seg.insert(seg.size(), pb);
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               pos = $urandom_range(0, m - 1);
               if ($urandom_range(0, 1) == 0) begin
                  seg.insert(seg.size(), search_word[pos/8][(pos%8)*8 +: 8]);
               end else begin
                  seg.insert(seg.size(), 8'($urandom));
               end
            end
         end
         foreach (seg[j]) begin
            send_char(seg[j], first_pending || $urandom_range(0, 59) == 0);
            first_pending = 1'b0;
            sent++;
         end
      end
   endtask

   initial begin
      bit quiet_phase;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.text_byte = '0;
      req_ch.first_of_text = 1'b0;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      for (int w = 0; w < WORD_COUNT; w++) begin
         search_word[w] = '0;
      end
      search_len = 1;
      search_k = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // registers as they come out of reset: pattern of one zero byte, no edits
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      wait_drained();

      // exact, substituted, deleted and inserted copies; unused indexes are ignored
      search_word[0] = 64'h0000_0000_4443_4241;
      search_len = 4;
      search_k = 1;
      program_search();
      reg_write(CSR_SPARE_6, '1);
      reg_write(CSR_SPARE_7, '1);
      reg_write_done();
      send_string("ABCD", 1'b1);
      send_string("ABXD", 1'b0);
      send_string("ACD", 1'b1);
      send_string("ABZCD", 1'b0);
      wait_drained();

      // zero length acts as one
      search_word[0] = 64'h0000_0000_0000_00FF;
      search_len = 0;
      search_k = 0;
      program_search();
      reg_write_done();
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b0);
      wait_drained();

      // oversized length acts as the full column, largest limit
      for (int w = 0; w < WORD_COUNT; w++) begin
         search_word[w] = '1;
      end
      search_len = 63;
      search_k = 31;
      program_search();
      reg_write_done();
      send_char(8'hFF, 1'b1);
      send_char(8'hFF, 1'b0);
      wait_drained();

      // lower the limit in the middle of a text
      search_k = 2;
      reg_write(CSR_LIMIT, WORD_W'(search_k));
      reg_write_done();
      send_char(8'hFF, 1'b0);
      send_char(8'h5A, 1'b0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         quiet_phase = (ph == RANDOM_PHASES - 1);
         sender_gaps = !quiet_phase && $urandom_range(0, 3) != 0;
         receiver_stalls = !quiet_phase && $urandom_range(0, 3) != 0;
         if (ph > 0 && $urandom_range(0, 3) == 0) begin
            // keep the column and count, change one setting
            if ($urandom_range(0, 1) == 0) begin
               search_k = $urandom_range(0, 31);
               reg_write(CSR_LIMIT, WORD_W'(search_k));
            end else begin
               search_len = $urandom_range(0, 40);
               reg_write(CSR_LENGTH, WORD_W'(search_len));
            end
            reg_write_done();
            emit_text($urandom_range(60, 110), 1'b0);
         end else begin
            pick_search();
            program_search();
            reg_write_done();
            emit_text($urandom_range(60, 110), 1'b1);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
